FILE: rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ACP_ASSERT_IMPL(label, clock, resetn, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (prop)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ACP_ASSERT_NEXT(label, clock, resetn, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/acp_pkg.sv
// Package with the codes, character constants and result type of the parser.
package acp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_FRAME     = 2'd0;
  localparam logic [1:0] KIND_FILTER    = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;
  localparam logic [1:0] KIND_OTHER     = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LENGTH   = 3'd1;
  localparam logic [2:0] ERR_IDE      = 3'd2;
  localparam logic [2:0] ERR_RTR      = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_ID_RANGE = 3'd5;
  localparam logic [2:0] ERR_SHORT    = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW = 3'd7;

  // Characters of the host protocol.
  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_STD   = 8'h54;  // 'T'
  localparam logic [7:0] CH_EXT   = 8'h74;  // 't'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
  localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Identifier limits.
  localparam logic [31:0] STD_ID_MAX = 32'h0000_07FF;
  localparam logic [31:0] EXT_ID_MAX = 32'h1FFF_FFFF;

  // One byte step handed from the input register to the decoder.
  typedef struct packed {
    logic       fire;
    logic [7:0] rx_byte;
  } step_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command_char;
    logic [2:0]  error_code;
    logic [3:0]  data_length;
    logic        extended_id;
    logic        remote_request;
    logic [28:0] frame_id;
    logic [63:0] frame_data;
    logic [1:0]  filter_slot;
    logic [31:0] filter_value;
  } result_t;

  // Hex digit value; bit 4 set marks a non-hex character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    return v;
  endfunction

  // Decimal digit test.
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: rtl/acp_decoder.sv
// Message state and incremental command decode, one byte per cycle.
module acp_decoder #(
  parameter int MAX_MESSAGE = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  acp_pkg::step_t   step,
  output acp_pkg::result_t result
);

  logic [7:0]  position_r, position_nxt;
  logic [7:0]  first_char_r, first_char_nxt;
  logic [3:0]  length_r, length_nxt;
  logic        ide_r, ide_nxt;
  logic        rtr_r, rtr_nxt;
  logic [31:0] hex_r, hex_nxt;
  logic [63:0] data_r, data_nxt;
  logic [2:0]  error_r, error_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      first_char_r <= '0;
      length_r     <= '0;
      ide_r        <= 1'b0;
      rtr_r        <= 1'b0;
      hex_r        <= '0;
      data_r       <= '0;
      error_r      <= acp_pkg::ERR_NONE;
    end else begin
      position_r   <= position_nxt;
      first_char_r <= first_char_nxt;
      length_r     <= length_nxt;
      ide_r        <= ide_nxt;
      rtr_r        <= rtr_nxt;
      hex_r        <= hex_nxt;
      data_r       <= data_nxt;
      error_r      <= error_nxt;
    end
  end

  // Next state: clear on open or close, flag an overflow once the buffer is full, otherwise store and decode the byte.
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  p;
    logic [4:0]  hv;
    logic [31:0] hex_new;
    logic [7:0]  idlen;
    logic [7:0]  d;
    logic        id_digit;
    logic        data_digit;
    logic [3:0]  nib;
    logic [31:0] id_max;
    logic        check_range;

    b           = step.rx_byte;
    p           = position_r;
    hv          = acp_pkg::hex_value(b);
    hex_new     = {hex_r[27:0], hv[3:0]};
    idlen       = ide_r ? 8'd8 : 8'd3;
    d           = '0;
    id_digit    = 1'b0;
    data_digit  = 1'b0;
    check_range = 1'b0;
    id_max      = acp_pkg::EXT_ID_MAX;

    position_nxt   = position_r;
    first_char_nxt = first_char_r;
    length_nxt     = length_r;
    ide_nxt        = ide_r;
    rtr_nxt        = rtr_r;
    hex_nxt        = hex_r;
    data_nxt       = data_r;
    error_nxt      = error_r;

    if (step.fire) begin
      if (b == acp_pkg::CH_OPEN || b == acp_pkg::CH_CLOSE) begin
        position_nxt = '0;
        length_nxt   = '0;
        ide_nxt      = 1'b0;
        rtr_nxt      = 1'b0;
        hex_nxt      = '0;
        data_nxt     = '0;
        error_nxt    = acp_pkg::ERR_NONE;
      end else if (position_r >= 8'(MAX_MESSAGE)) begin
        if (error_r == acp_pkg::ERR_NONE) error_nxt = acp_pkg::ERR_OVERFLOW;
      end else begin
        position_nxt = position_r + 8'd1;
        if (p == 8'd0) begin
          first_char_nxt = b;
        end else if (error_r == acp_pkg::ERR_NONE) begin
          if (first_char_r == acp_pkg::CH_STD) begin
            if (p == 8'd1) begin
              if (b < acp_pkg::CH_ZERO || b > acp_pkg::CH_EIGHT)
                error_nxt = acp_pkg::ERR_LENGTH;
              else
                length_nxt = 4'(b - acp_pkg::CH_ZERO);
            end else if (p == 8'd2) begin
              if (!acp_pkg::is_digit(b)) error_nxt = acp_pkg::ERR_IDE;
              else ide_nxt = (b != acp_pkg::CH_ZERO);
            end else if (p == 8'd3) begin
              if (!acp_pkg::is_digit(b)) error_nxt = acp_pkg::ERR_RTR;
              else rtr_nxt = (b != acp_pkg::CH_ZERO);
            end else if (p < 8'd4 + idlen) begin
              id_digit    = 1'b1;
              check_range = (p == 8'd3 + idlen);
              id_max      = ide_r ? acp_pkg::EXT_ID_MAX : acp_pkg::STD_ID_MAX;
            end else begin
              d          = p - 8'd4 - idlen;
              data_digit = (d < {3'b000, length_r, 1'b0});
            end
          end else if (first_char_r == acp_pkg::CH_EXT) begin
            if (p <= 8'd8) begin
              id_digit    = 1'b1;
              check_range = (p == 8'd8);
            end else begin
              d          = p - 8'd9;
              data_digit = (d < 8'd16);
            end
          end else if (first_char_r >= acp_pkg::CH_FIVE &&
                       first_char_r <= acp_pkg::CH_EIGHT) begin
            id_digit = (p <= 8'd8);
          end
        end
      end
    end

    // Identifier or filter word digit, with the range check on the last one.
    if (id_digit) begin
      if (hv[4]) begin
        error_nxt = acp_pkg::ERR_HEX;
      end else begin
        hex_nxt = hex_new;
        if (check_range && hex_new > id_max) error_nxt = acp_pkg::ERR_ID_RANGE;
      end
    end

    // Data digit: high nibble of each byte comes first.
    nib = {d[3:1], ~d[0]};
    if (data_digit) begin
      if (hv[4]) error_nxt = acp_pkg::ERR_HEX;
      else data_nxt = data_r | (64'(hv[3:0]) << {nib, 2'b00});
    end
  end

  // Result of the message as it stands; taken when the close byte fires.
  always_comb begin
    logic [7:0] cmd;
    logic [2:0] err;
    logic [7:0] need;
    logic       is_filter;

    cmd       = (position_r != 8'd0) ? first_char_r : 8'd0;
    err       = error_r;
    is_filter = (cmd >= acp_pkg::CH_FIVE) && (cmd <= acp_pkg::CH_EIGHT);
    need      = '0;
    if (cmd == acp_pkg::CH_STD) begin
      need = (position_r < 8'd4) ? 8'd4
           : 8'd4 + (ide_r ? 8'd8 : 8'd3) + {3'b000, length_r, 1'b0};
    end else if (cmd == acp_pkg::CH_EXT) begin
      need = 8'd25;
    end else if (is_filter) begin
      need = 8'd9;
    end
    if (position_r != 8'd0 && err == acp_pkg::ERR_NONE && position_r < need)
      err = acp_pkg::ERR_SHORT;

    result              = '0;
    result.command_char = cmd;
    if (err != acp_pkg::ERR_NONE) begin
      result.kind       = acp_pkg::KIND_MALFORMED;
      result.error_code = err;
    end else if (cmd == acp_pkg::CH_STD || cmd == acp_pkg::CH_EXT) begin
      result.kind           = acp_pkg::KIND_FRAME;
      result.data_length    = (cmd == acp_pkg::CH_EXT) ? 4'd8 : length_r;
      result.extended_id    = (cmd == acp_pkg::CH_EXT) ? 1'b1 : ide_r;
      result.remote_request = (cmd == acp_pkg::CH_EXT) ? 1'b0 : rtr_r;
      result.frame_id       = hex_r[28:0];
      result.frame_data     = data_r;
    end else if (is_filter) begin
      result.kind         = acp_pkg::KIND_FILTER;
      result.filter_slot  = 2'(cmd - acp_pkg::CH_FIVE);
      result.filter_value = hex_r;
    end else begin
      result.kind = acp_pkg::KIND_OTHER;
    end
  end

endmodule

FILE: rtl/acp_out_reg.sv
// Result register of the parser with its valid and stall handshake.
module acp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  acp_pkg::result_t load_data,
  output logic             room,
  input  logic             out_stall,
  output logic             out_valid,
  output acp_pkg::result_t out_data
);

  logic             valid_r, valid_nxt;
  acp_pkg::result_t data_r;

  // The register can take a new item when empty or being drained.
  assign room = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (room) valid_nxt = load;
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, held while stalled.
  always_ff @(posedge clk) begin
    if (room && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/ascii_can_command_parser.sv
// Top level of the ASCII CAN command parser: input register, decoder, result register.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_rx_byte
//   out_     output     out_valid / out_stall kind, command, error, frame and filter fields
//
// Each byte is decoded while it sits in the input register and updates the message
// state at the next edge; one byte per cycle is sustained, but a close byte waits on a
// full, stalled result register while every other byte moves on regardless of out_stall.
// A close byte that fires yields a result item in the output register in the next cycle.
// Reset (synchronous, active low) clears the message state and both valid flags.
module ascii_can_command_parser #(
  parameter int MAX_MESSAGE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_command_char,
  output logic [2:0]  out_error_code,
  output logic [3:0]  out_data_length,
  output logic        out_extended_id,
  output logic        out_remote_request,
  output logic [28:0] out_frame_id,
  output logic [63:0] out_frame_data,
  output logic [1:0]  out_filter_slot,
  output logic [31:0] out_filter_value
);

`include "assert_macros.svh"

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       byte_r;
  logic             is_close;
  logic             room;
  logic             advance;
  acp_pkg::step_t   step;
  acp_pkg::result_t result;
  acp_pkg::result_t out_data;

  // A held byte moves on unless it is a close byte facing a full result register.
  assign is_close = (byte_r == acp_pkg::CH_CLOSE);
  assign advance  = !is_close || room;
  assign in_stall = in_valid_r && !advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) in_valid_nxt = in_valid;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  assign step.fire    = in_valid_r && advance;
  assign step.rx_byte = byte_r;

  acp_decoder #(
    .MAX_MESSAGE(MAX_MESSAGE)
  ) u_decoder (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .result(result)
  );

  acp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step.fire && is_close),
    .load_data(result),
    .room     (room),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign out_kind           = out_data.kind;
  assign out_command_char   = out_data.command_char;
  assign out_error_code     = out_data.error_code;
  assign out_data_length    = out_data.data_length;
  assign out_extended_id    = out_data.extended_id;
  assign out_remote_request = out_data.remote_request;
  assign out_frame_id       = out_data.frame_id;
  assign out_frame_data     = out_data.frame_data;
  assign out_filter_slot    = out_data.filter_slot;
  assign out_filter_value   = out_data.filter_value;

  // Only malformed results carry an error code.
  `ACP_ASSERT_IMPL(a_err_only_malformed, clk, rst_n,
    out_valid && out_kind != acp_pkg::KIND_MALFORMED,
    out_error_code == acp_pkg::ERR_NONE, "error code on a well-formed result")

  // Frame fields stay zero on results that are not frames.
  `ACP_ASSERT_IMPL(a_frame_fields_zero, clk, rst_n,
    out_valid && out_kind != acp_pkg::KIND_FRAME,
    out_frame_data == 64'd0 && out_frame_id == 29'd0 && out_data_length == 4'd0,
    "frame fields set on a non-frame result")

  // A frame never reports more than eight data bytes.
  `ACP_ASSERT_IMPL(a_frame_length, clk, rst_n,
    out_valid && out_kind == acp_pkg::KIND_FRAME,
    out_data_length <= 4'd8, "frame length above eight")

  // A close byte that fires shows up as a result item in the next cycle.
  `ACP_ASSERT_NEXT(a_close_yields_result, clk, rst_n,
    step.fire && is_close, out_valid, "close byte gave no result")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the ASCII CAN command parser.
module tb_top;

  localparam int MSG_MAX     = 128;
  localparam int HOLD_CYCLES = 200;
  localparam int TIMEOUT     = 400000;

  // Letter ranges of hex digits, and the command and fill bytes of the overflow test.
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_OTHER_V = 8'h56;
  localparam logic [7:0] CH_FILL    = 8'h61;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_command_char;
  logic [2:0]  out_error_code;
  logic [3:0]  out_data_length;
  logic        out_extended_id;
  logic        out_remote_request;
  logic [28:0] out_frame_id;
  logic [63:0] out_frame_data;
  logic [1:0]  out_filter_slot;
  logic [31:0] out_filter_value;

  // Parser state mirrored by the predictor.
  int unsigned msg_len  = 0;
  logic [7:0]  msg_cmd  = 8'h00;
  logic [3:0]  len_digit = 4'd0;
  logic        ide_bit  = 1'b0;
  logic        rtr_bit  = 1'b0;
  logic [31:0] id_acc   = '0;
  logic [63:0] data_acc = '0;
  logic [2:0]  msg_err  = acp_pkg::ERR_NONE;

  acp_pkg::result_t expected_results[$];

  int bytes_sent     = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  ascii_can_command_parser #(.MAX_MESSAGE(MSG_MAX)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_command_char  (out_command_char),
    .out_error_code    (out_error_code),
    .out_data_length   (out_data_length),
    .out_extended_id   (out_extended_id),
    .out_remote_request(out_remote_request),
    .out_frame_id      (out_frame_id),
    .out_frame_data    (out_frame_data),
    .out_filter_slot   (out_filter_slot),
    .out_filter_value  (out_filter_value)
  );

  always #1 clk = ~clk;

  // Value of a hex character; bit 4 flags a character that is not hex.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= acp_pkg::CH_ZERO && c <= acp_pkg::CH_NINE) return {1'b0, c[3:0]};
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 5'(c - CH_UPPER_A + 8'd10);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 5'(c - CH_LOWER_A + 8'd10);
    return 5'h10;
  endfunction

  // Hex character for a nibble, letters in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return acp_pkg::CH_ZERO + 8'(n);
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
  endfunction

  function automatic logic is_filter_cmd(input logic [7:0] c);
    return (c >= acp_pkg::CH_FIVE) && (c <= acp_pkg::CH_EIGHT);
  endfunction

  task automatic clear_message();
    msg_len   = 0;
    len_digit = 4'd0;
    ide_bit   = 1'b0;
    rtr_bit   = 1'b0;
    id_acc    = '0;
    data_acc  = '0;
    msg_err   = acp_pkg::ERR_NONE;
  endtask

  // Only the first error of a message is kept.
  task automatic note_error(input logic [2:0] code);
    if (msg_err == acp_pkg::ERR_NONE) msg_err = code;
  endtask

  task automatic shift_id_digit(input logic [7:0] b);
    logic [4:0] h;
    h = nibble_of(b);
    if (h[4]) note_error(acp_pkg::ERR_HEX);
    else id_acc = {id_acc[27:0], h[3:0]};
  endtask

  // Even digit index is the high nibble of its byte.
  task automatic place_data_digit(input logic [7:0] b, input int unsigned d);
    logic [4:0] h;
    int unsigned shift;
    h = nibble_of(b);
    shift = 8 * (d >> 1) + ((d & 1) ? 0 : 4);
    if (h[4]) note_error(acp_pkg::ERR_HEX);
    else data_acc = data_acc | (64'(h[3:0]) << shift);
  endtask

  // Decodes one byte at message position p (p > 0, no error so far).
  task automatic decode_field(input logic [7:0] b, input int unsigned p);
    int unsigned idl;
    idl = ide_bit ? 8 : 3;
    if (msg_cmd == acp_pkg::CH_STD) begin
      if (p == 1) begin
        if (b < acp_pkg::CH_ZERO || b > acp_pkg::CH_EIGHT) note_error(acp_pkg::ERR_LENGTH);
        else len_digit = 4'(b - acp_pkg::CH_ZERO);
      end else if (p == 2) begin
        if (b < acp_pkg::CH_ZERO || b > acp_pkg::CH_NINE) note_error(acp_pkg::ERR_IDE);
        else ide_bit = (b != acp_pkg::CH_ZERO);
      end else if (p == 3) begin
        if (b < acp_pkg::CH_ZERO || b > acp_pkg::CH_NINE) note_error(acp_pkg::ERR_RTR);
        else rtr_bit = (b != acp_pkg::CH_ZERO);
      end else if (p < 4 + idl) begin
        shift_id_digit(b);
        if (msg_err == acp_pkg::ERR_NONE && p == 3 + idl &&
            id_acc > (ide_bit ? acp_pkg::EXT_ID_MAX : acp_pkg::STD_ID_MAX))
          note_error(acp_pkg::ERR_ID_RANGE);
      end else if (p - 4 - idl < 2 * len_digit) begin
        place_data_digit(b, p - 4 - idl);
      end
    end else if (msg_cmd == acp_pkg::CH_EXT) begin
      if (p <= 8) begin
        shift_id_digit(b);
        if (msg_err == acp_pkg::ERR_NONE && p == 8 && id_acc > acp_pkg::EXT_ID_MAX)
          note_error(acp_pkg::ERR_ID_RANGE);
      end else if (p - 9 < 16) begin
        place_data_digit(b, p - 9);
      end
    end else if (is_filter_cmd(msg_cmd) && p <= 8) begin
      shift_id_digit(b);
    end
  endtask

  // Predicts the parser for one accepted byte; a close byte queues one result.
  task automatic decode_host_byte(input logic [7:0] b);
    acp_pkg::result_t r;
    int unsigned need;
    if (b == acp_pkg::CH_OPEN) begin
      clear_message();
    end else if (b != acp_pkg::CH_CLOSE) begin
      if (msg_len >= MSG_MAX) begin
        note_error(acp_pkg::ERR_OVERFLOW);
      end else begin
        msg_len++;
        if (msg_len == 1) msg_cmd = b;
        else if (msg_err == acp_pkg::ERR_NONE) decode_field(b, msg_len - 1);
      end
    end else begin
      r = '0;
      r.command_char = (msg_len > 0) ? msg_cmd : 8'h00;
      r.error_code = msg_err;
      // A message that stops before its required fields is short.
      if (msg_len > 0 && msg_err == acp_pkg::ERR_NONE) begin
        need = 0;
        if (msg_cmd == acp_pkg::CH_STD)
          need = (msg_len < 4) ? 4 : 4 + (ide_bit ? 8 : 3) + 2 * len_digit;
        else if (msg_cmd == acp_pkg::CH_EXT) need = 25;
        else if (is_filter_cmd(msg_cmd)) need = 9;
        if (msg_len < need) r.error_code = acp_pkg::ERR_SHORT;
      end
      if (r.error_code != acp_pkg::ERR_NONE) begin
        r.kind = acp_pkg::KIND_MALFORMED;
      end else if (r.command_char == acp_pkg::CH_STD ||
                   r.command_char == acp_pkg::CH_EXT) begin
        r.kind           = acp_pkg::KIND_FRAME;
        r.data_length    = (r.command_char == acp_pkg::CH_EXT) ? 4'd8 : len_digit;
        r.extended_id    = (r.command_char == acp_pkg::CH_EXT) ? 1'b1 : ide_bit;
        r.remote_request = (r.command_char == acp_pkg::CH_EXT) ? 1'b0 : rtr_bit;
        r.frame_id       = id_acc[28:0];
        r.frame_data     = data_acc;
      end else if (is_filter_cmd(r.command_char)) begin
        r.kind         = acp_pkg::KIND_FILTER;
        r.filter_slot  = 2'(r.command_char - acp_pkg::CH_FIVE);
        r.filter_value = id_acc;
      end else begin
        r.kind = acp_pkg::KIND_OTHER;
      end
      expected_results.push_back(r);
      clear_message();
    end
  endtask

  // Receiver: long hold-off when requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Compares each accepted result item with the oldest prediction.
  always @(posedge clk) begin : check_results
    acp_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: kind %0d command %0h error %0d",
                   out_kind, out_command_char, out_error_code);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        check_field("kind", 64'(want.kind), 64'(out_kind));
        check_field("command_char", 64'(want.command_char), 64'(out_command_char));
        check_field("error_code", 64'(want.error_code), 64'(out_error_code));
        check_field("data_length", 64'(want.data_length), 64'(out_data_length));
        check_field("extended_id", 64'(want.extended_id), 64'(out_extended_id));
        check_field("remote_request", 64'(want.remote_request),
                    64'(out_remote_request));
        check_field("frame_id", 64'(want.frame_id), 64'(out_frame_id));
        check_field("frame_data", want.frame_data, out_frame_data);
        check_field("filter_slot", 64'(want.filter_slot), 64'(out_filter_slot));
        check_field("filter_value", 64'(want.filter_value), 64'(out_filter_value));
      end
    end
  end

  // Offers one byte and returns at the edge where it is accepted.
  // Valid stays high after return so that back-to-back items have no gap.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    decode_host_byte(b);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_body(input logic [7:0] body[$], input bit with_open);
    if (with_open) send_byte(acp_pkg::CH_OPEN);
    foreach (body[i]) send_byte(body[i]);
    send_byte(acp_pkg::CH_CLOSE);
  endtask

  // Appends n hex digits of v, most significant first.
  task automatic add_hex(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) q.push_back(hex_char(v[4*i +: 4]));
  endtask

  task automatic test_directed_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("<>");
    send_text("<T000000>");
    send_text("<T8007FF0123456789abcdef>");
    send_text("<T2951FFFFFFFa5C3>");
    send_text("<T2011230102>");
    send_text("<T000123extra>");
    send_text("<t1FFFFFFF0011223344556677>");
    // A message that starts without an open byte.
    send_text("T100456AB>");
    // Extreme byte values as the command byte.
    send_byte(acp_pkg::CH_OPEN);
    send_byte(8'h00);
    send_byte(acp_pkg::CH_CLOSE);
    send_byte(acp_pkg::CH_OPEN);
    send_byte(8'hFF);
    send_byte(acp_pkg::CH_CLOSE);
    wait_drain();
  endtask

  task automatic test_directed_errors();
    send_text("<T9000000>");
    send_text("<T0x0000>");
    send_text("<T00/000>");
    send_text("<T000G00>");
    send_text("<T100000zz>");
    send_text("<T000800>");
    send_text("<T01020000000>");
    send_text("<t200000000011223344556677>");
    send_text("<t123>");
    send_text("<T>");
    send_text("<T10>");
    send_text("<T100>");
    // The earliest error wins.
    send_text("<T9x/>");
    // An open byte throws away the partial message.
    send_text("<5123<6ABCDEF01>");
    wait_drain();
  endtask

  task automatic test_filters_and_others();
    send_text("<5FFFFFFFF>");
    send_text("<600000000>");
    send_text("<7DEADbeef>");
    send_text("<812345678xyz>");
    send_text("<5123>");
    send_text("<5ghijklmn>");
    send_text("<V>");
    send_text("<O12>");
    send_text("<4ABCDEF01>");
    send_text("<9ABCDEF01>");
    wait_drain();
  endtask

  // Messages at the buffer limit and one byte beyond it.
  task automatic test_overflow();
    logic [7:0] body[$];
    body = {CH_OTHER_V};
    repeat (MSG_MAX - 1) body.push_back(CH_FILL);
    send_body(body, 1'b1);
    body.push_back(CH_FILL);
    send_body(body, 1'b1);
    // A complete standard frame followed by too many trailing bytes.
    body = {acp_pkg::CH_STD, acp_pkg::CH_ZERO, acp_pkg::CH_ZERO, acp_pkg::CH_ZERO};
    add_hex(body, 32'h7FF, 3);
    repeat (MSG_MAX + 5) body.push_back(CH_FILL);
    send_body(body, 1'b1);
    // An earlier error is kept over the overflow.
    body = {acp_pkg::CH_STD, acp_pkg::CH_NINE};
    repeat (MSG_MAX + 2) body.push_back(CH_FILL);
    send_body(body, 1'b1);
    wait_drain();
  endtask

  // One random message, mostly well formed, some broken, some noise.
  task automatic send_random_message();
    logic [7:0] body[$];
    int unsigned pick, len, n, keep, m;
    logic ext;
    logic [31:0] id;
    bit with_open;
    pick = $urandom_range(99);
    with_open = ($urandom_range(19) != 0);
    if (pick < 35) begin
      len = $urandom_range(8);
      ext = 1'($urandom_range(1));
      body.push_back(acp_pkg::CH_STD);
      body.push_back(acp_pkg::CH_ZERO + 8'(len));
      body.push_back(ext ? acp_pkg::CH_ZERO + 8'($urandom_range(9, 1)) : acp_pkg::CH_ZERO);
      body.push_back(acp_pkg::CH_ZERO + 8'($urandom_range(9)));
      if (ext)
        id = ($urandom_range(9) == 0) ? ($urandom | 32'h2000_0000)
                                      : {3'b000, 29'($urandom)};
      else
        id = ($urandom_range(9) == 0) ? $urandom_range(12'hFFF, 12'h800)
                                      : $urandom_range(11'h7FF);
      add_hex(body, id, ext ? 8 : 3);
      repeat (len) add_hex(body, $urandom, 2);
    end else if (pick < 50) begin
      body.push_back(acp_pkg::CH_EXT);
      id = ($urandom_range(9) == 0) ? ($urandom | 32'h2000_0000)
                                    : {3'b000, 29'($urandom)};
      add_hex(body, id, 8);
      repeat (8) add_hex(body, $urandom, 2);
    end else if (pick < 65) begin
      body.push_back(acp_pkg::CH_FIVE + 8'($urandom_range(3)));
      add_hex(body, $urandom, 8);
    end else if (pick < 77) begin
      n = $urandom_range(6);
      repeat (n + 1) body.push_back(8'($urandom));
    end else if (pick < 80) begin
      // Long message around the buffer limit, no markers inside.
      n = $urandom_range(MSG_MAX + 12, MSG_MAX - 8);
      repeat (n) body.push_back(8'($urandom_range(8'h7E, 8'h40)));
    end else begin
      // Raw noise, markers included.
      with_open = 1'($urandom_range(1));
      n = $urandom_range(12, 1);
      repeat (n) body.push_back(8'($urandom));
    end
    // Trailing bytes, corrupted bytes and cut-off messages.
    if (pick < 65) begin
      if ($urandom_range(5) == 0) begin
        n = $urandom_range(3, 1);
        repeat (n) body.push_back(hex_char(4'($urandom)));
      end
      m = $urandom_range(99);
      if (m < 12) begin
        body[$urandom_range(body.size() - 1, 1)] = 8'($urandom);
      end else if (m < 22) begin
        keep = $urandom_range(body.size() - 1, 1);
        while (body.size() > keep) void'(body.pop_back());
      end
    end
    send_body(body, with_open);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int budget);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) send_random_message();
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering closed messages.
  task automatic test_output_hold();
    logic [7:0] body[$];
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 8; k++) begin
      body = {acp_pkg::CH_FIVE + 8'(k % 4)};
      add_hex(body, $urandom, 8);
      send_body(body, 1'b1);
      send_text("<V>");
    end
    wait_drain();
    send_text("<T1001234F>");
    wait_drain();
    send_text("<t00000000FFFFFFFFFFFFFFFF>");
    wait_drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_directed_errors();
    test_filters_and_others();
    test_overflow();
    test_random_traffic(0, 0, 250);
    test_random_traffic(72, 0, 250);
    test_random_traffic(0, 72, 250);
    test_random_traffic(20, 20, 250);
    test_output_hold();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d host bytes, checked %0d results, %0d mismatches.",
             bytes_sent, results_seen, mismatches);
    $display("Covered frames, filters, every error code, overflow, idle mixes and a long hold.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: ascii_can_command_parser.f
+incdir+rtl
rtl/acp_pkg.sv
rtl/acp_decoder.sv
rtl/acp_out_reg.sv
rtl/ascii_can_command_parser.sv
verif/tb_top.sv
